@@ hdl/circular_bucket_queue_assert.svh @@
// Assertion macros for the bucket queue.
`ifndef CIRCULAR_BUCKET_QUEUE_ASSERT_SVH
`define CIRCULAR_BUCKET_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CBQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("circular_bucket_queue: assertion failed");

// next-cycle implication
`define CBQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("circular_bucket_queue: assertion failed");

`else

`define CBQ_ASSERT_IMP(name, clk, rstn, ante, cons)
`define CBQ_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/cbq_pkg.sv @@
package cbq_pkg;

	localparam int MW_W    = 8;
	localparam int NB_W    = MW_W + 1;
	localparam int ROUND_W = 24;
	localparam int DIST_W  = 32;
	localparam int NODE_W  = 16;
	localparam int STAT_W  = 3;

	localparam logic [ROUND_W-1:0] ROUND_MAX = '1;
	localparam logic [MW_W-1:0] MAX_WEIGHT_RST = '1;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_CLEAR   = 2'd2
	} cbq_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_POOL_FULL = 3'd2,
		ST_WEIGHT    = 3'd3,
		ST_ROUND_OVF = 3'd4
	} cbq_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_INS_LINK,
		S_SCAN,
		S_EXT_RD,
		S_EXT_POOL,
		S_EXT_WR,
		S_DONE
	} cbq_state_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [NODE_W-1:0] node_id;
		logic [MW_W-1:0]   weight;
	} cbq_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [NODE_W-1:0] out_node;
		logic [DIST_W-1:0] distance;
		logic              now_empty;
	} cbq_res_t;

endpackage

@@ hdl/circular_bucket_queue.sv @@
// Insert: states INS_RD, INS_WR and, when the target bucket already holds entries, INS_LINK, then DONE.
// Extract: SCAN past empty buckets, EXT_RD, EXT_POOL, EXT_WR, then DONE; empty-queue extract,
// clear, no-op and rejected inserts go straight to DONE. One transaction at a time; the sequencer and the
// single port of the bucket and pool memories set this order of states.
// Async reset empties the queue and sets max_weight to 255; memories are not cleared.
`include "circular_bucket_queue_assert.svh"

module circular_bucket_queue
	import cbq_pkg::*;
#(
	parameter int MAX_BUCKETS = 256,
	parameter int POOL_SLOTS  = 4096,
	parameter int NODE_BITS   = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  cbq_cmd_t        cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output cbq_res_t        res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [MW_W-1:0] cfg_data
);

	localparam int NB_CAP = (MAX_BUCKETS < (1 << MW_W)) ? MAX_BUCKETS : (1 << MW_W);
	localparam int ACT_W  = $clog2(NB_CAP);
	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int CNT_W  = $clog2(POOL_SLOTS + 1);

	cbq_state_t state_q, state_d;

	logic [MW_W-1:0]    max_weight_q;
	logic [NB_CAP-1:0]  ne_q;
	logic [SLOT_W-1:0]  free_head_q;
	logic [CNT_W-1:0]   fresh_q;
	logic [CNT_W-1:0]   occ_q;
	logic [ACT_W-1:0]   act_q;
	logic [ROUND_W-1:0] round_q;
	logic               res_valid_q;

	logic [ACT_W-1:0]     bid_q;
	logic [NODE_BITS-1:0] node_q;
	logic                 use_free_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    tail_old_q;
	logic                 last_q;
	logic [DIST_W-1:0]    prod_q;
	cbq_status_t          status_q;
	logic [NODE_W-1:0]    out_node_q;
	logic [DIST_W-1:0]    dist_q;
	cbq_res_t             res_q;

	logic [SLOT_W-1:0]    bkt_head_mem [NB_CAP];
	logic [SLOT_W-1:0]    bkt_tail_mem [NB_CAP];
	logic [NODE_BITS-1:0] pool_node_mem [POOL_SLOTS];
	logic [SLOT_W-1:0]    pool_link_mem [POOL_SLOTS];
	logic [SLOT_W-1:0]    bkt_head_rd_q, bkt_tail_rd_q;
	logic [NODE_BITS-1:0] pool_node_rd_q;
	logic [SLOT_W-1:0]    pool_link_rd_q;

	logic [ACT_W-1:0]  bkt_addr;
	logic              head_we, tail_we;
	logic [SLOT_W-1:0] head_wd;
	logic [SLOT_W-1:0] pool_addr;
	logic              node_we, link_we;
	logic [SLOT_W-1:0] link_wd;

	logic              cmd_acc, cfg_acc, res_load;
	logic [NB_W-1:0]   nb, nb_raw, id_sum, a_inc;
	logic [ACT_W-1:0]  bid_next;
	logic              wt_bad, pool_full, a_wrap;
	logic [DIST_W:0]   prod_full;

	assign cfg_ready = (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE) || cfg_valid;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign res_load  = (state_q == S_DONE) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign nb_raw = NB_W'(max_weight_q) + NB_W'(1);
	assign nb     = (nb_raw > NB_W'(NB_CAP)) ? NB_W'(NB_CAP) : nb_raw;

	// target bucket: sum stays below 2*nb, so one subtract wraps it
	assign id_sum    = NB_W'(act_q) + NB_W'(cmd.weight);
	assign bid_next  = ACT_W'((id_sum >= nb) ? (id_sum - nb) : id_sum);
	assign wt_bad    = NB_W'(cmd.weight) > (nb - NB_W'(1));
	assign pool_full = occ_q >= CNT_W'(POOL_SLOTS);

	assign a_inc     = NB_W'(act_q) + NB_W'(1);
	assign a_wrap    = a_inc >= nb;
	assign prod_full = (DIST_W + 1)'(round_q) * (DIST_W + 1)'(nb);

	always_comb begin
		state_d = state_q;
		bkt_addr = bid_q;
		head_we = 1'b0;
		tail_we = 1'b0;
		head_wd = slot_q;
		pool_addr = free_head_q;
		node_we = 1'b0;
		link_we = 1'b0;
		link_wd = free_head_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.op)
						OP_INSERT: state_d = (wt_bad || pool_full) ? S_DONE : S_INS_RD;
						OP_EXTRACT: state_d = (occ_q == '0) ? S_DONE : S_SCAN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_INS_RD: begin
				state_d = S_INS_WR;
			end
			S_INS_WR: begin
				tail_we = 1'b1;
				head_we = !ne_q[bid_q];
				pool_addr = slot_q;
				node_we = 1'b1;
				state_d = ne_q[bid_q] ? S_INS_LINK : S_DONE;
			end
			S_INS_LINK: begin
				// chain new slot behind the old tail
				pool_addr = tail_old_q;
				link_we = 1'b1;
				link_wd = slot_q;
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (ne_q[act_q])
					state_d = S_EXT_RD;
			end
			S_EXT_RD: begin
				bkt_addr = act_q;
				state_d = S_EXT_POOL;
			end
			S_EXT_POOL: begin
				pool_addr = bkt_head_rd_q;
				state_d = S_EXT_WR;
			end
			S_EXT_WR: begin
				bkt_addr = act_q;
				head_we = !last_q;
				head_wd = pool_link_rd_q;
				pool_addr = slot_q;
				link_we = 1'b1;
				link_wd = free_head_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_weight_q <= MAX_WEIGHT_RST;
			ne_q <= '0;
			free_head_q <= '0;
			fresh_q <= '0;
			occ_q <= '0;
			act_q <= '0;
			round_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;

			if (cfg_acc || (cmd_acc && cmd.op == OP_CLEAR)) begin
				if (cfg_acc)
					max_weight_q <= cfg_data;
				ne_q <= '0;
				free_head_q <= '0;
				fresh_q <= '0;
				occ_q <= '0;
				act_q <= '0;
				round_q <= '0;
			end else begin
				case (state_q)
					S_INS_RD: begin
						if (!use_free_q)
							fresh_q <= fresh_q + CNT_W'(1);
					end
					S_INS_WR: begin
						if (use_free_q)
							free_head_q <= pool_link_rd_q;
						ne_q[bid_q] <= 1'b1;
						occ_q <= occ_q + CNT_W'(1);
					end
					S_SCAN: begin
						if (!ne_q[act_q]) begin
							act_q <= a_wrap ? '0 : ACT_W'(a_inc);
							if (a_wrap && round_q != ROUND_MAX)
								round_q <= round_q + ROUND_W'(1);
						end
					end
					S_EXT_WR: begin
						if (last_q)
							ne_q[act_q] <= 1'b0;
						free_head_q <= slot_q;
						occ_q <= occ_q - CNT_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					bid_q <= bid_next;
					node_q <= NODE_BITS'(cmd.node_id);
					use_free_q <= fresh_q > occ_q;
					out_node_q <= '0;
					dist_q <= '0;
					case (cmd.op)
						OP_INSERT: begin
							if (wt_bad)
								status_q <= ST_WEIGHT;
							else if (pool_full)
								status_q <= ST_POOL_FULL;
							else
								status_q <= ST_OK;
						end
						OP_EXTRACT: status_q <= (occ_q == '0) ? ST_EMPTY : ST_OK;
						default: status_q <= ST_OK;
					endcase
				end
			end
			S_INS_RD: begin
				slot_q <= use_free_q ? free_head_q : fresh_q[SLOT_W-1:0];
			end
			S_INS_WR: begin
				tail_old_q <= bkt_tail_rd_q;
			end
			S_SCAN: begin
				if (!ne_q[act_q] && a_wrap && round_q == ROUND_MAX)
					status_q <= ST_ROUND_OVF;
			end
			S_EXT_RD: begin
				prod_q <= prod_full[DIST_W-1:0];
			end
			S_EXT_POOL: begin
				slot_q <= bkt_head_rd_q;
				last_q <= (bkt_tail_rd_q == bkt_head_rd_q);
			end
			S_EXT_WR: begin
				out_node_q <= NODE_W'(pool_node_rd_q);
				dist_q <= prod_q + DIST_W'(act_q);
			end
			default: ;
		endcase
		if (res_load) begin
			res_q.status <= status_q;
			res_q.out_node <= out_node_q;
			res_q.distance <= dist_q;
			res_q.now_empty <= (occ_q == '0);
		end
	end

	// bucket memory: head and tail fields, one address
	always_ff @(posedge clk) begin
		if (head_we)
			bkt_head_mem[bkt_addr] <= head_wd;
		if (tail_we)
			bkt_tail_mem[bkt_addr] <= slot_q;
		bkt_head_rd_q <= bkt_head_mem[bkt_addr];
		bkt_tail_rd_q <= bkt_tail_mem[bkt_addr];
	end

	// pool memory: node and link fields, one address
	always_ff @(posedge clk) begin
		if (node_we)
			pool_node_mem[pool_addr] <= node_q;
		if (link_we)
			pool_link_mem[pool_addr] <= link_wd;
		pool_node_rd_q <= pool_node_mem[pool_addr];
		pool_link_rd_q <= pool_link_mem[pool_addr];
	end

	`CBQ_ASSERT_IMP(a_free_count, clk, arst_n, 1'b1, fresh_q >= occ_q)
	`CBQ_ASSERT_IMP(a_act_in_range, clk, arst_n, 1'b1, NB_W'(act_q) < nb)
	`CBQ_ASSERT_IMP(a_scan_has_entry, clk, arst_n, state_q == S_SCAN, ne_q != '0)
	`CBQ_ASSERT_IMP(a_empty_no_bucket, clk, arst_n, state_q == S_IDLE && occ_q == '0, ne_q == '0)
	`CBQ_ASSERT_NXT(a_cfg_empties, clk, arst_n, cfg_acc, occ_q == '0 && act_q == '0)

endmodule

@@ tb/tb_circular_bucket_queue.sv @@
module tb_circular_bucket_queue;
	import cbq_pkg::*;

	localparam int POOL_DEPTH = 4096;
	localparam int BUCKET_CAP = 256;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_WAIT = 300;
	localparam logic [1:0] OP_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cbq_cmd_t cmd;
	logic res_valid;
	logic res_stall;
	cbq_res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [MW_W-1:0] cfg_data;

	// predictor state
	logic [MW_W-1:0] mw_reg;
	logic [11:0] b_head [BUCKET_CAP];
	logic [11:0] b_tail [BUCKET_CAP];
	bit b_busy [BUCKET_CAP];
	logic [11:0] slot_link [POOL_DEPTH];
	logic [NODE_W-1:0] slot_vertex [POOL_DEPTH];
	int unsigned free_top;
	int unsigned fresh_used;
	int unsigned cur_bucket;
	int unsigned live_count;
	logic [ROUND_W-1:0] wraps;

	cbq_res_t queue_answers [$];
	cbq_res_t head_ans;
	int fail_count = 0;
	int cycle_count = 0;
	bit idle_en;
	bit rx_idle_en;
	int rx_hold;

	circular_bucket_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void drain_queue();
		foreach (b_busy[i]) b_busy[i] = 1'b0;
		free_top = 0;
		fresh_used = 0;
		cur_bucket = 0;
		wraps = '0;
		live_count = 0;
	endfunction

	function automatic cbq_res_t dial_step(cbq_cmd_t c);
		cbq_res_t r;
		int unsigned nb;
		int unsigned id;
		int unsigned slot;
		int unsigned a;
		int unsigned steps;
		logic [63:0] d;
		r = '0;
		r.status = ST_OK;
		nb = int'(mw_reg) + 1;
		if (nb > BUCKET_CAP) nb = BUCKET_CAP;
		case (c.op)
			OP_INSERT: begin
				if (c.weight > nb - 1) begin
					r.status = ST_WEIGHT;
				end else if (live_count >= POOL_DEPTH) begin
					r.status = ST_POOL_FULL;
				end else begin
					id = cur_bucket + c.weight;
					if (id >= nb) id -= nb;
					// freed slots go out before fresh ones
					if (fresh_used > live_count) begin
						slot = free_top % POOL_DEPTH;
						free_top = slot_link[slot];
					end else begin
						slot = fresh_used % POOL_DEPTH;
						fresh_used++;
					end
					slot_vertex[slot] = c.node_id;
					if (b_busy[id]) begin
						slot_link[b_tail[id]] = 12'(slot);
					end else begin
						b_head[id] = 12'(slot);
						b_busy[id] = 1'b1;
					end
					b_tail[id] = 12'(slot);
					live_count++;
				end
			end
			OP_EXTRACT: begin
				if (live_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					a = cur_bucket;
					steps = 0;
					while (!b_busy[a] && steps < nb) begin
						a++;
						if (a >= nb) begin
							a = 0;
							if (wraps == ROUND_MAX) r.status = ST_ROUND_OVF;
							else wraps++;
						end
						steps++;
					end
					cur_bucket = a;
					slot = b_head[a];
					r.out_node = slot_vertex[slot];
					d = 64'(wraps) * nb + a;
					r.distance = d[DIST_W-1:0];
					if (b_tail[a] == slot) b_busy[a] = 1'b0;
					else b_head[a] = slot_link[slot];
					slot_link[slot] = 12'(free_top);
					free_top = slot;
					live_count--;
				end
			end
			OP_CLEAR: drain_queue();
			default: ;
		endcase
		r.now_empty = (live_count == 0);
		return r;
	endfunction

	// one command transaction; prediction happens at acceptance
	task automatic send_cmd(logic [1:0] op, logic [NODE_W-1:0] node, logic [MW_W-1:0] w);
		cbq_cmd_t c;
		c.op = op;
		c.node_id = node;
		c.weight = w;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		queue_answers.insert(queue_answers.size(), dial_step(c));
		@(negedge clk);
	endtask

	// only while idle; a write also empties the queue
	task automatic set_max_weight(logic [MW_W-1:0] v);
		cmd_valid <= 1'b0;
		wait (queue_answers.size() == 0);
		repeat (8) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		mw_reg = v;
		drain_queue();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (queue_answers.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result transaction with nothing pending: %p", res);
			end else begin
				head_ans = queue_answers[0];
				queue_answers.delete(0);
				check_field("status", head_ans.status, res.status);
				check_field("out_node", head_ans.out_node, res.out_node);
				check_field("distance", head_ans.distance, res.distance);
				check_field("now_empty", head_ans.now_empty, res.now_empty);
			end
		end
	end

	// result side: long hold on request, else random stall bursts
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				res_stall <= 1'b1;
				repeat (rx_hold - 1) @(negedge clk);
				rx_hold = 0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic test_empty_and_noop();
		send_cmd(OP_EXTRACT, 16'hFFFF, 8'hFF);
		send_cmd(OP_NOP, 16'h5A5A, 8'h11);
		send_cmd(OP_CLEAR, 16'h0000, 8'h00);
	endtask

	task automatic test_default_range();
		send_cmd(OP_INSERT, 16'h0000, 8'd0);
		send_cmd(OP_INSERT, 16'hFFFF, 8'd255);
		send_cmd(OP_INSERT, 16'h1234, 8'd255);
		repeat (4) send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
	endtask

	task automatic test_single_bucket();
		set_max_weight(8'd0);
		send_cmd(OP_INSERT, 16'h0005, 8'd0);
		send_cmd(OP_INSERT, 16'h0006, 8'd1);
		send_cmd(OP_INSERT, 16'h0007, 8'd255);
		send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
		send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
	endtask

	task automatic test_wrap();
		set_max_weight(8'd1);
		send_cmd(OP_INSERT, 16'h0101, 8'd1);
		send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
		send_cmd(OP_INSERT, 16'h0202, 8'd1);
		send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
		send_cmd(OP_INSERT, 16'h0303, 8'd2);
		send_cmd(OP_INSERT, 16'h0404, 8'd0);
		send_cmd(OP_CLEAR, 16'h0000, 8'd0);
		send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
	endtask

	task automatic test_cfg_clears();
		send_cmd(OP_INSERT, 16'hA0A0, 8'd0);
		send_cmd(OP_INSERT, 16'hB0B0, 8'd1);
		set_max_weight(MAX_WEIGHT_RST);
		send_cmd(OP_EXTRACT, 16'h0000, 8'd0);
	endtask

	task automatic test_slot_reuse();
		set_max_weight(8'd15);
		idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (32) send_cmd(OP_INSERT, 16'($urandom), 8'($urandom_range(0, 15)));
		send_cmd(OP_INSERT, 16'h00BB, 8'd200);
		repeat (24) send_cmd(OP_EXTRACT, 16'($urandom), 8'($urandom));
		// freed slots are handed out again here
		repeat (24) send_cmd(OP_INSERT, 16'($urandom), 8'($urandom_range(0, 15)));
		send_cmd(OP_INSERT, 16'h00CC, 8'd15);
		repeat (16) send_cmd(OP_EXTRACT, 16'($urandom), 8'($urandom));
		send_cmd(OP_CLEAR, 16'h0000, 8'd0);
	endtask

	task automatic test_backpressure();
		set_max_weight(8'd63);
		idle_en = 1'b0;
		rx_hold = 300;
		repeat (8) send_cmd(OP_INSERT, 16'($urandom), 8'($urandom_range(0, 63)));
		repeat (9) send_cmd(OP_EXTRACT, 16'($urandom), 8'($urandom));
	endtask

	task automatic run_mix(logic [MW_W-1:0] mw, int count, bit with_idle);
		int pick;
		logic [MW_W-1:0] w;
		logic [NODE_W-1:0] node;
		set_max_weight(mw);
		idle_en = with_idle;
		rx_idle_en = with_idle;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			node = 16'($urandom);
			w = ($urandom_range(0, 3) == 0) ? mw : 8'($urandom_range(0, int'(mw)));
			if (pick < 4 && mw != MAX_WEIGHT_RST)
				send_cmd(OP_INSERT, node, 8'($urandom_range(int'(mw) + 1, 255)));
			else if (pick < 6)
				send_cmd(OP_CLEAR, node, 8'($urandom));
			else if (pick < 8)
				send_cmd(OP_NOP, node, 8'($urandom));
			else if (pick < 58 || (live_count == 0 && pick < 80))
				send_cmd(OP_INSERT, node, w);
			else
				send_cmd(OP_EXTRACT, node, 8'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_en = 1'b1;
		rx_idle_en = 1'b1;
		rx_hold = 0;
		mw_reg = MAX_WEIGHT_RST;
		drain_queue();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_and_noop();
		test_default_range();
		test_single_bucket();
		test_wrap();
		test_cfg_clears();
		test_slot_reuse();
		test_backpressure();
		run_mix(8'd1, 100, 1'b1);
		run_mix(MAX_WEIGHT_RST, 120, 1'b1);
		run_mix(8'd7, 100, 1'b1);
		run_mix(8'($urandom_range(2, 254)), 100, 1'b1);
		run_mix(8'd0, 40, 1'b1);
		run_mix(8'd31, 120, 1'b0);

		cmd_valid <= 1'b0;
		wait (queue_answers.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
